### sv/sdt_pkg.sv
`default_nettype none
package sdt_pkg;

    localparam int ADDR_W        = 48;
    localparam int KIND_W        = 2;
    localparam int LEVEL_W       = 8;
    localparam int TIME_W        = 48;
    localparam int SLOT_W        = 5;
    localparam int OUTCOME_W     = 3;
    localparam int DEFAULT_DEPTH = 24;

    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT        = 3'd0,
        OUT_NEW        = 3'd1,
        OUT_REPLACED   = 3'd2,
        OUT_READ_OK    = 3'd3,
        OUT_READ_EMPTY = 3'd4
    } outcome_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [KIND_W-1:0]  kind;
        logic [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]  stamp;
    } entry_t;

    typedef struct packed {
        logic match;
        logic older;
    } cmp_res_t;

endpackage
`default_nettype wire

### sv/sdt_table_ram.sv
`default_nettype none
module sdt_table_ram #(
    parameter int DEPTH = sdt_pkg::DEFAULT_DEPTH,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  wire logic                aclk,
    input  wire logic                wr_en,
    input  wire logic [IDX_W-1:0]    wr_addr,
    input  wire sdt_pkg::entry_t     wr_data,
    input  wire logic                rd_en,
    input  wire logic [IDX_W-1:0]    rd_addr,
    output sdt_pkg::entry_t          rd_data
);

    sdt_pkg::entry_t mem [DEPTH];
    sdt_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### sv/sdt_cmp_unit.sv
`default_nettype none
module sdt_cmp_unit (
    input  wire sdt_pkg::entry_t                  stored,
    input  wire logic [sdt_pkg::ADDR_W-1:0]       key_addr,
    input  wire logic [sdt_pkg::KIND_W-1:0]       key_kind,
    input  wire logic [sdt_pkg::TIME_W-1:0]       best_stamp,
    output sdt_pkg::cmp_res_t                     res
);

    assign res.match = (stored.kind == key_kind) && (stored.addr == key_addr);
    assign res.older = stored.stamp < best_stamp;

endmodule
`default_nettype wire

### sv/seen_device_table_oldest_evict_core.sv
`default_nettype none
// Seen-device table, oldest entry replaced when full.
// Input channel s_*: one item per transfer. A report (operation 0) looks for a
// stored entry with the same address and type and refreshes it; otherwise it
// fills the next free slot or, with the table full, replaces the entry with
// the smallest timestamp (lowest slot on a tie). A read (operation 1) returns
// the entry at read_slot, or outcome 4 with zero data for an empty slot.
// Output channel m_*: one result per item, held in an output register.
// A report reads and checks one stored table entry per cycle through the single
// RAM read port and compare unit, then makes one write; with an empty table it
// skips the scan. A read of a valid slot goes through one RAM read, and a read
// of an empty slot skips the RAM. The next input transfer can be taken in the
// same cycle that m_valid rises.
// s_ready is high only while no item is in work; one item at a time.
// A new item may be taken while the previous result still waits on m_ready;
// its result is held until the output register is free.
// Reset (aresetn low, synchronous) empties the table and drops any result.
module seen_device_table_oldest_evict_core #(
    parameter int TABLE_DEPTH = sdt_pkg::DEFAULT_DEPTH
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_operation,
    input  wire logic [sdt_pkg::ADDR_W-1:0]          s_dev_address,
    input  wire logic [sdt_pkg::KIND_W-1:0]          s_address_kind,
    input  wire logic signed [sdt_pkg::LEVEL_W-1:0]  s_signal_level,
    input  wire logic [sdt_pkg::TIME_W-1:0]          s_time_stamp,
    input  wire logic [sdt_pkg::SLOT_W-1:0]          s_read_slot,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [sdt_pkg::SLOT_W-1:0]               m_slot_used,
    output logic [sdt_pkg::OUTCOME_W-1:0]            m_outcome,
    output logic [sdt_pkg::SLOT_W-1:0]               m_entries_held,
    output logic [sdt_pkg::ADDR_W-1:0]               m_entry_address,
    output logic [sdt_pkg::KIND_W-1:0]               m_entry_kind,
    output logic signed [sdt_pkg::LEVEL_W-1:0]       m_entry_level,
    output logic [sdt_pkg::TIME_W-1:0]               m_entry_time
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CW    = (CNT_W > sdt_pkg::SLOT_W) ? CNT_W : sdt_pkg::SLOT_W;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_WRITE  = 6'b000100,
        ST_RDREQ  = 6'b001000,
        ST_RDDATA = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]           fill_reg;
    logic [CNT_W-1:0]           issue_reg;
    logic                       cmp_vld_reg;
    logic [IDX_W-1:0]           cmp_idx_reg;
    logic                       found_reg;
    logic [IDX_W-1:0]           hit_idx_reg;
    logic [IDX_W-1:0]           best_idx_reg;
    logic [sdt_pkg::TIME_W-1:0] best_stamp_reg;
    sdt_pkg::entry_t            item_reg;
    logic [sdt_pkg::SLOT_W-1:0] rslot_reg;

    logic [sdt_pkg::SLOT_W-1:0]    res_slot_reg;
    sdt_pkg::outcome_t             res_outcome_reg;
    sdt_pkg::entry_t               res_entry_reg;

    logic                          m_valid_reg;
    logic [sdt_pkg::SLOT_W-1:0]    m_slot_reg;
    logic [sdt_pkg::OUTCOME_W-1:0] m_outcome_reg;
    logic [sdt_pkg::SLOT_W-1:0]    m_held_reg;
    sdt_pkg::entry_t               m_entry_reg;

    logic              s_xfer;
    logic              issue_more;
    logic              scan_last;
    logic              table_full;
    logic              rd_ok;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    sdt_pkg::entry_t   rd_data;
    sdt_pkg::entry_t   in_entry;
    sdt_pkg::cmp_res_t cmp_res;
    logic              take_best;
    logic              out_free;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_xfer     = s_valid && s_ready;
    assign issue_more = issue_reg < fill_reg;
    assign scan_last  = cmp_vld_reg && ((CNT_W'(cmp_idx_reg) + CNT_W'(1)) == fill_reg);
    assign table_full = (fill_reg == CNT_W'(TABLE_DEPTH));
    assign rd_ok      = CW'(s_read_slot) < CW'(fill_reg);
    assign out_free   = !m_valid_reg || m_ready;
    assign take_best  = (cmp_idx_reg == '0) || cmp_res.older;

    assign in_entry.addr  = s_dev_address;
    assign in_entry.kind  = s_address_kind;
    assign in_entry.level = s_signal_level;
    assign in_entry.stamp = s_time_stamp;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = issue_reg[IDX_W-1:0];
        if (state_reg == ST_SCAN && issue_more) begin
            rd_en = 1'b1;
        end else if (state_reg == ST_RDREQ) begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(rslot_reg);
        end
    end

    always_comb begin
        wr_en = (state_reg == ST_WRITE);
        if (found_reg) begin
            wr_addr = hit_idx_reg;
        end else if (!table_full) begin
            wr_addr = fill_reg[IDX_W-1:0];
        end else begin
            wr_addr = best_idx_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_operation == sdt_pkg::OP_READ) begin
                        state_next = rd_ok ? ST_RDREQ : ST_DONE;
                    end else begin
                        state_next = (fill_reg == '0) ? ST_WRITE : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:  state_next = ST_DONE;
            ST_RDREQ:  state_next = ST_RDDATA;
            ST_RDDATA: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    sdt_table_ram #(
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sdt_cmp_unit u_cmp (
        .stored     (rd_data),
        .key_addr   (item_reg.addr),
        .key_kind   (item_reg.kind),
        .best_stamp (best_stamp_reg),
        .res        (cmp_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (s_xfer) begin
                item_reg  <= in_entry;
                rslot_reg <= s_read_slot;
                issue_reg <= '0;
                found_reg <= 1'b0;
                if (s_operation == sdt_pkg::OP_READ) begin
                    res_slot_reg    <= s_read_slot;
                    res_outcome_reg <= rd_ok ? sdt_pkg::OUT_READ_OK : sdt_pkg::OUT_READ_EMPTY;
                    res_entry_reg   <= '0;
                end
            end

            cmp_vld_reg <= 1'b0;
            if (state_reg == ST_SCAN) begin
                if (issue_more) begin
                    issue_reg   <= issue_reg + CNT_W'(1);
                    cmp_vld_reg <= 1'b1;
                    cmp_idx_reg <= issue_reg[IDX_W-1:0];
                end
                if (cmp_vld_reg) begin
                    if (cmp_res.match && !found_reg) begin
                        found_reg   <= 1'b1;
                        hit_idx_reg <= cmp_idx_reg;
                    end
                    if (take_best) begin
                        best_idx_reg   <= cmp_idx_reg;
                        best_stamp_reg <= rd_data.stamp;
                    end
                end
            end

            if (state_reg == ST_WRITE) begin
                res_slot_reg  <= sdt_pkg::SLOT_W'(wr_addr);
                res_entry_reg <= item_reg;
                if (found_reg) begin
                    res_outcome_reg <= sdt_pkg::OUT_HIT;
                end else if (!table_full) begin
                    res_outcome_reg <= sdt_pkg::OUT_NEW;
                    fill_reg        <= fill_reg + CNT_W'(1);
                end else begin
                    res_outcome_reg <= sdt_pkg::OUT_REPLACED;
                end
            end

            if (state_reg == ST_RDDATA) begin
                res_entry_reg <= rd_data;
            end

            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg   <= 1'b1;
                m_slot_reg    <= res_slot_reg;
                m_outcome_reg <= res_outcome_reg;
                m_held_reg    <= sdt_pkg::SLOT_W'(fill_reg);
                m_entry_reg   <= res_entry_reg;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_slot_used     = m_slot_reg;
    assign m_outcome       = m_outcome_reg;
    assign m_entries_held  = m_held_reg;
    assign m_entry_address = m_entry_reg.addr;
    assign m_entry_kind    = m_entry_reg.kind;
    assign m_entry_level   = $signed(m_entry_reg.level);
    assign m_entry_time    = m_entry_reg.stamp;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && !found_reg && !table_full)
        |=> fill_reg == $past(fill_reg) + CNT_W'(1))
        else $error("new entry did not grow the fill count");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && cmp_vld_reg) |-> CNT_W'(cmp_idx_reg) < fill_reg)
        else $error("compare of an entry beyond the fill count");

    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the done state");

endmodule
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int ADDR_W        = sdt_pkg::ADDR_W;
    localparam int KIND_W        = sdt_pkg::KIND_W;
    localparam int LEVEL_W       = sdt_pkg::LEVEL_W;
    localparam int TIME_W        = sdt_pkg::TIME_W;
    localparam int SLOT_W        = sdt_pkg::SLOT_W;
    localparam int OUTCOME_W     = sdt_pkg::OUTCOME_W;
    localparam logic OP_REPORT   = sdt_pkg::OP_REPORT;
    localparam logic OP_READ     = sdt_pkg::OP_READ;

    localparam int TABLE_SIZE   = sdt_pkg::DEFAULT_DEPTH;
    localparam int POOL_SIZE    = 40;
    localparam int RANDOM_ITEMS = 1000;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [TIME_W-1:0] STAMP_MAX = '1;
    localparam logic [ADDR_W-1:0] ADDR_MAX  = '1;

    typedef struct {
        logic                      op;
        logic [ADDR_W-1:0]         addr;
        logic [KIND_W-1:0]         kind;
        logic signed [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]         stamp;
        logic [SLOT_W-1:0]         rslot;
        bit                        drain;
    } device_item_t;

    typedef struct {
        logic [SLOT_W-1:0]         slot;
        logic [OUTCOME_W-1:0]      outcome;
        logic [SLOT_W-1:0]         held;
        logic [ADDR_W-1:0]         addr;
        logic [KIND_W-1:0]         kind;
        logic signed [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]         stamp;
    } table_result_t;

    logic                      aclk           = 1'b0;
    logic                      aresetn        = 1'b0;
    logic                      s_valid        = 1'b0;
    logic                      s_ready;
    logic                      s_operation    = OP_REPORT;
    logic [ADDR_W-1:0]         s_dev_address  = '0;
    logic [KIND_W-1:0]         s_address_kind = '0;
    logic signed [LEVEL_W-1:0] s_signal_level = '0;
    logic [TIME_W-1:0]         s_time_stamp   = '0;
    logic [SLOT_W-1:0]         s_read_slot    = '0;
    logic                      m_valid;
    logic                      m_ready        = 1'b0;
    logic [SLOT_W-1:0]         m_slot_used;
    logic [OUTCOME_W-1:0]      m_outcome;
    logic [SLOT_W-1:0]         m_entries_held;
    logic [ADDR_W-1:0]         m_entry_address;
    logic [KIND_W-1:0]         m_entry_kind;
    logic signed [LEVEL_W-1:0] m_entry_level;
    logic [TIME_W-1:0]         m_entry_time;

    seen_device_table_oldest_evict_core #(
        .TABLE_DEPTH(TABLE_SIZE)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_dev_address  (s_dev_address),
        .s_address_kind (s_address_kind),
        .s_signal_level (s_signal_level),
        .s_time_stamp   (s_time_stamp),
        .s_read_slot    (s_read_slot),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_slot_used    (m_slot_used),
        .m_outcome      (m_outcome),
        .m_entries_held (m_entries_held),
        .m_entry_address(m_entry_address),
        .m_entry_kind   (m_entry_kind),
        .m_entry_level  (m_entry_level),
        .m_entry_time   (m_entry_time)
    );

    device_item_t  report_queue[$];
    table_result_t table_expect[$];

    logic [ADDR_W-1:0]         seen_addr[TABLE_SIZE];
    logic [KIND_W-1:0]         seen_kind[TABLE_SIZE];
    logic signed [LEVEL_W-1:0] seen_level[TABLE_SIZE];
    logic [TIME_W-1:0]         seen_stamp[TABLE_SIZE];
    int unsigned               seen_count = 0;

    int   failures    = 0;
    int   cycle_count = 0;
    logic s_fire      = 1'b0;
    logic m_fire      = 1'b0;
    int   sender_wait = 0;
    int   sink_wait   = 0;
    int   sink_hold;
    bit   sender_quiet = 1'b0;
    bit   sink_quiet   = 1'b0;
    device_item_t staged;

    always #5 aclk = ~aclk;

    function automatic table_result_t apply_item(device_item_t it);
        table_result_t r;
        int            slot;
        int            i;
        r.slot    = it.rslot;
        r.outcome = sdt_pkg::OUT_READ_EMPTY;
        r.addr    = '0;
        r.kind    = '0;
        r.level   = '0;
        r.stamp   = '0;
        if (it.op == OP_READ) begin
            if (it.rslot < seen_count) begin
                r.outcome = sdt_pkg::OUT_READ_OK;
                r.addr    = seen_addr[it.rslot];
                r.kind    = seen_kind[it.rslot];
                r.level   = seen_level[it.rslot];
                r.stamp   = seen_stamp[it.rslot];
            end
            r.held = seen_count[SLOT_W-1:0];
            return r;
        end
        slot = -1;
        for (i = 0; i < seen_count; i++) begin
            if (slot < 0 && seen_kind[i] == it.kind && seen_addr[i] == it.addr) begin
                slot = i;
            end
        end
        if (slot >= 0) begin
            r.outcome = sdt_pkg::OUT_HIT;
        end else if (seen_count < TABLE_SIZE) begin
            slot = seen_count;
            seen_count++;
            r.outcome = sdt_pkg::OUT_NEW;
        end else begin
            slot = 0;
            for (i = 1; i < TABLE_SIZE; i++) begin
                if (seen_stamp[i] < seen_stamp[slot]) begin
                    slot = i;
                end
            end
            r.outcome = sdt_pkg::OUT_REPLACED;
        end
        seen_addr[slot]  = it.addr;
        seen_kind[slot]  = it.kind;
        seen_level[slot] = it.level;
        seen_stamp[slot] = it.stamp;
        r.slot  = slot[SLOT_W-1:0];
        r.held  = seen_count[SLOT_W-1:0];
        r.addr  = it.addr;
        r.kind  = it.kind;
        r.level = it.level;
        r.stamp = it.stamp;
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge aclk) begin
        device_item_t  taken;
        table_result_t want;
        if (!aresetn) begin
            s_fire <= 1'b0;
            m_fire <= 1'b0;
        end else begin
            s_fire <= s_valid && s_ready;
            m_fire <= m_valid && m_ready;
            if (s_valid && s_ready) begin
                taken.op    = s_operation;
                taken.addr  = s_dev_address;
                taken.kind  = s_address_kind;
                taken.level = s_signal_level;
                taken.stamp = s_time_stamp;
                taken.rslot = s_read_slot;
                taken.drain = 1'b0;
                table_expect.push_back(apply_item(taken));
            end
            if (m_valid && m_ready) begin
                if (table_expect.size() == 0) begin
                    $error("result transfer with nothing outstanding");
                    failures++;
                end else begin
                    want = table_expect.pop_front();
                    check_field("slot_used", want.slot, m_slot_used);
                    check_field("outcome", want.outcome, m_outcome);
                    check_field("entries_held", want.held, m_entries_held);
                    check_field("entry_address", want.addr, m_entry_address);
                    check_field("entry_kind", want.kind, m_entry_kind);
                    check_field("entry_level", want.level, m_entry_level);
                    check_field("entry_time", want.stamp, m_entry_time);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid     <= 1'b0;
            sender_wait <= 0;
        end else if (!s_valid || s_fire) begin
            if (sender_wait != 0) begin
                s_valid     <= 1'b0;
                sender_wait <= sender_wait - 1;
            end else if (report_queue.size() != 0 &&
                         !(report_queue[0].drain && table_expect.size() != 0)) begin
                staged = report_queue.pop_front();
                s_operation    <= staged.op;
                s_dev_address  <= staged.addr;
                s_address_kind <= staged.kind;
                s_signal_level <= staged.level;
                s_time_stamp   <= staged.stamp;
                s_read_slot    <= staged.rslot;
                s_valid        <= 1'b1;
                if ($urandom_range(0, 39) == 0) sender_quiet = !sender_quiet;
                sender_wait <= sender_quiet ? 0 : $urandom_range(0, 11);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_wait <= 0;
        end else if (m_fire) begin
            if ($urandom_range(0, 39) == 0) sink_quiet = !sink_quiet;
            sink_hold = sink_quiet ? 0 : $urandom_range(0, 11);
            sink_wait <= sink_hold;
            m_ready   <= (sink_hold == 0);
        end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            m_ready   <= (sink_wait == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_item(logic op, logic [ADDR_W-1:0] addr, logic [KIND_W-1:0] kind,
                             logic [LEVEL_W-1:0] level, logic [TIME_W-1:0] stamp,
                             logic [SLOT_W-1:0] rslot, bit drain);
        device_item_t it;
        it.op    = op;
        it.addr  = addr;
        it.kind  = kind;
        it.level = level;
        it.stamp = stamp;
        it.rslot = rslot;
        it.drain = drain;
        report_queue.push_back(it);
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    initial begin
        logic [ADDR_W-1:0] pool_addr[POOL_SIZE];
        logic [KIND_W-1:0] pool_kind[POOL_SIZE];
        logic [ADDR_W-1:0] addr;
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] clock_us;
        logic [TIME_W-1:0] tie_base;
        int                n;
        int                idx;
        int                pick;
        int                stamp_mode;
        int                pool_span;
        int                phase_end;
        bit                mark_drain;

        // directed: empty reads, extremes, type-only difference, refresh
        push_item(OP_READ, '0, '0, '0, '0, 5'd0, 1'b0);
        push_item(OP_READ, ADDR_MAX, 2'd3, 8'hFF, STAMP_MAX, 5'd31, 1'b0);
        push_item(OP_REPORT, '0, 2'd0, 8'h80, '0, 5'd0, 1'b0);
        push_item(OP_REPORT, ADDR_MAX, 2'd3, 8'h7F, STAMP_MAX, 5'd31, 1'b0);
        push_item(OP_REPORT, '0, 2'd1, 8'h00, 48'd1, 5'd0, 1'b0);
        push_item(OP_REPORT, ADDR_MAX, 2'd2, 8'hFF, 48'd2, 5'd0, 1'b0);
        push_item(OP_REPORT, '0, 2'd0, 8'hFF, 48'h8000_0000_0000, 5'd0, 1'b0);
        push_item(OP_READ, '0, '0, '0, '0, 5'd0, 1'b0);
        push_item(OP_READ, '0, '0, '0, '0, 5'd1, 1'b0);
        push_item(OP_READ, '0, '0, '0, '0, 5'd3, 1'b0);
        push_item(OP_READ, '0, '0, '0, '0, 5'd4, 1'b0);
        push_item(OP_READ, '0, '0, '0, '0, 5'd23, 1'b0);
        push_item(OP_READ, '0, '0, '0, '0, 5'd24, 1'b0);

        pool_addr[0] = '0;
        pool_addr[1] = ADDR_MAX;
        pool_kind[0] = 2'd3;
        pool_kind[1] = 2'd0;
        for (n = 2; n < POOL_SIZE; n++) begin
            pool_addr[n] = rand48();
            pool_kind[n] = 2'($urandom_range(0, 3));
        end

        clock_us   = 48'd1000;
        tie_base   = '0;
        stamp_mode = 0;
        pool_span  = POOL_SIZE - 1;
        phase_end  = 0;
        mark_drain = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == phase_end) begin
                stamp_mode = $urandom_range(0, 3);
                pool_span  = $urandom_range(8, POOL_SIZE - 1);
                tie_base   = rand48();
                phase_end  = n + $urandom_range(60, 120);
                mark_drain = 1'b1;
            end
            if ($urandom_range(0, 4) == 0) begin
                push_item(OP_READ, rand48(), 2'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)), rand48(),
                          5'($urandom_range(0, 31)), mark_drain);
            end else begin
                pick = $urandom_range(0, 19);
                idx  = $urandom_range(0, pool_span);
                if (pick < 17) begin
                    addr = pool_addr[idx];
                    kind = pool_kind[idx];
                end else if (pick < 18) begin
                    addr = pool_addr[idx];
                    kind = pool_kind[idx] ^ 2'($urandom_range(1, 3));
                end else begin
                    addr = rand48();
                    kind = 2'($urandom_range(0, 3));
                end
                case (stamp_mode)
                    0: begin
                        clock_us = clock_us + 48'($urandom_range(1, 5000));
                        stamp    = clock_us;
                    end
                    1: stamp = tie_base + 48'($urandom_range(0, 1));
                    2: stamp = rand48();
                    default: stamp = STAMP_MAX - 48'($urandom_range(0, 3));
                endcase
                push_item(OP_REPORT, addr, kind, 8'($urandom_range(0, 255)), stamp,
                          5'($urandom_range(0, 31)), mark_drain);
            end
            mark_drain = 1'b0;
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (report_queue.size() != 0 || s_valid) @(negedge aclk);
        while (table_expect.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
